### rtl/scle_pkg.sv
package scle_pkg;

  localparam int unsigned Depth = 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned DataW = 32;
  localparam logic [AddrW-1:0] HeadIdx  = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0] LastFree = AddrW'(Depth - 2);

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_READ   = 3'd2,
    FN_LOCATE = 3'd3,
    FN_PRED   = 3'd4,
    FN_SUCC   = 3'd5,
    FN_CLEAR  = 3'd6
  } func_e;

  typedef enum logic [1:0] {RD_HEAD, RD_ZERO, RD_LINK} rd_sel_e;
  typedef enum logic [2:0] {LA_ZERO, LA_J, LA_K, LA_ADDR, LA_HEAD, LA_INIT} lwr_addr_e;
  typedef enum logic [1:0] {LD_LINK, LD_J, LD_NULL, LD_INIT} lwr_data_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_ONE, CNT_INC} cnt_op_e;
  typedef enum logic [1:0] {LEN_HOLD, LEN_INC, LEN_DEC, LEN_CLR} len_op_e;
  typedef enum logic [1:0] {V_ZERO, V_ELEM, V_PREV} vsel_e;

  typedef struct packed {
    logic      cap;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      save_j;
    logic      save_k;
    logic      lwr_en;
    lwr_addr_e lwr_addr;
    lwr_data_e lwr_data;
    logic      ewr_en;
    cnt_op_e   cnt_op;
    len_op_e   len_op;
    logic      init_inc;
    logic      res_load;
    logic      res_fail;
    vsel_e     res_vsel;
    logic      res_fpos;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       ins_ok;
    logic       pos_ok;
    logic       link_zero;
    logic       hit;
    logic       match;
    logic       cnt_gt1;
    logic       cnt_eq_len;
    logic       len_zero;
    logic       init_last;
  } sts_t;

endpackage

### rtl/static_cursor_list_engine.sv
// Ordered list kept as linked entries in a 1024-entry link and element memory; entry 0
// heads the free chain and entry 1023 is the list header, so up to 1022 elements fit.
// After reset the block walks the link memory once to build the free chain, with busy_o
// high throughout. A transaction is taken when start_i is high and busy_o is low. Each
// transaction walks the list from the header, one link-memory read per cycle: insert,
// delete and read walk to the given position, locate, predecessor and successor scan at
// most the whole list, and clear walks to its last element. A rejected request, an insert
// into a full store and a clear of an empty list finish without a walk. The result appears
// for exactly one cycle with done_o high and must be captured then; busy_o is low in that
// cycle, so the next start may coincide.
module static_cursor_list_engine import scle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [2:0]       func_i,
  input  logic [AddrW-1:0] position_i,
  input  logic [DataW-1:0] value_i,
  output logic             done_o,
  output logic             status_o,
  output logic [DataW-1:0] value_out_o,
  output logic [AddrW-1:0] found_position_o,
  output logic [AddrW-1:0] length_o
);

  cmd_t cmd;
  sts_t sts;

  scle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  scle_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .value_out_o     (value_out_o),
    .found_position_o(found_position_o),
    .length_o        (length_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction not busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (length_o <= LastFree)) else $error("length beyond capacity");

endmodule

### rtl/scle_dp.sv
module scle_dp import scle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       func_i,
  input  logic [AddrW-1:0] position_i,
  input  logic [DataW-1:0] value_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             done_o,
  output logic             status_o,
  output logic [DataW-1:0] value_out_o,
  output logic [AddrW-1:0] found_position_o,
  output logic [AddrW-1:0] length_o
);

  logic [AddrW-1:0] link_mem [Depth];
  logic [DataW-1:0] elem_mem [Depth];

  logic [2:0]       func_q;
  logic [AddrW-1:0] pos_q, j_q, k_q, addr_q, link_rd_q, cnt_q, len_q, len_d, init_q;
  logic [DataW-1:0] key_q, elem_rd_q, prev_q;
  logic             done_q, status_q;
  logic [DataW-1:0] value_q;
  logic [AddrW-1:0] fpos_q, length_q;

  logic [AddrW-1:0] rd_addr, lwr_addr, lwr_data, target;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD: rd_addr = HeadIdx;
      RD_ZERO: rd_addr = '0;
      default: rd_addr = link_rd_q;
    endcase
    case (cmd_i.lwr_addr)
      LA_ZERO: lwr_addr = '0;
      LA_J:    lwr_addr = j_q;
      LA_K:    lwr_addr = k_q;
      LA_ADDR: lwr_addr = addr_q;
      LA_HEAD: lwr_addr = HeadIdx;
      default: lwr_addr = init_q;
    endcase
    case (cmd_i.lwr_data)
      LD_LINK: lwr_data = link_rd_q;
      LD_J:    lwr_data = j_q;
      LD_NULL: lwr_data = '0;
      default: lwr_data = (init_q >= LastFree) ? '0 : init_q + 1'b1;
    endcase
    case (func_q)
      FN_READ:  target = pos_q + 1'b1;
      FN_CLEAR: target = len_q + 1'b1;
      default:  target = pos_q;
    endcase
    case (cmd_i.len_op)
      LEN_INC: len_d = len_q + 1'b1;
      LEN_DEC: len_d = len_q - 1'b1;
      LEN_CLR: len_d = '0;
      default: len_d = len_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
    if (cmd_i.rd_en) begin
      link_rd_q <= link_mem[rd_addr];
      addr_q    <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ewr_en) begin
      elem_mem[j_q] <= key_q;
    end
    if (cmd_i.rd_en) begin
      elem_rd_q <= elem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      func_q <= func_i;
      pos_q  <= position_i;
      key_q  <= value_i;
    end
    if (cmd_i.save_j) begin
      j_q <= link_rd_q;
    end
    if (cmd_i.save_k) begin
      k_q <= addr_q;
    end
    case (cmd_i.cnt_op)
      CNT_ZERO: cnt_q <= '0;
      CNT_ONE:  cnt_q <= AddrW'(1);
      CNT_INC: begin
        cnt_q  <= cnt_q + 1'b1;
        prev_q <= elem_rd_q;
      end
      default: ;
    endcase
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_fail;
      fpos_q   <= (cmd_i.res_fpos && !cmd_i.res_fail) ? cnt_q : '0;
      length_q <= len_d;
      if (cmd_i.res_fail) begin
        value_q <= '0;
      end else begin
        case (cmd_i.res_vsel)
          V_ELEM:  value_q <= elem_rd_q;
          V_PREV:  value_q <= prev_q;
          default: value_q <= '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      init_q <= '0;
      done_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      done_q <= cmd_i.res_load;
      if (cmd_i.init_inc) begin
        init_q <= init_q + 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.ins_ok     = (pos_q != '0) && ({1'b0, pos_q} <= ({1'b0, len_q} + 1'b1));
    sts_o.pos_ok     = (pos_q != '0) && (pos_q <= len_q);
    sts_o.link_zero  = (link_rd_q == '0);
    sts_o.hit        = (cnt_q == target);
    sts_o.match      = (cnt_q != '0) && (elem_rd_q == key_q);
    sts_o.cnt_gt1    = (cnt_q > AddrW'(1));
    sts_o.cnt_eq_len = (cnt_q == len_q);
    sts_o.len_zero   = (len_q == '0);
    sts_o.init_last  = (init_q == HeadIdx);
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign value_out_o      = value_q;
  assign found_position_o = fpos_q;
  assign length_o         = length_q;

endmodule

### rtl/scle_ctrl.sv
module scle_ctrl import scle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DISP, ST_INS1, ST_INS2, ST_INS3, ST_INS4, ST_WALK,
    ST_DEL2, ST_DEL3, ST_DEL4, ST_CLR2, ST_CLR3, ST_CLR4, ST_SCAN, ST_SNEXT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_INIT;
        cmd_o.lwr_data = LD_INIT;
        cmd_o.init_inc = 1'b1;
        if (sts_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DISP;
        end
      end
      ST_DISP: begin
        case (sts_i.func) inside
          FN_INSERT: begin
            if (sts_i.ins_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ZERO;
              state_d      = ST_INS1;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_fail = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          FN_DELETE, FN_READ: begin
            if (sts_i.pos_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_HEAD;
              cmd_o.cnt_op = CNT_ONE;
              state_d      = ST_WALK;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_fail = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          FN_LOCATE, FN_PRED, FN_SUCC: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_HEAD;
            cmd_o.cnt_op = CNT_ZERO;
            state_d      = ST_SCAN;
          end
          FN_CLEAR: begin
            if (sts_i.len_zero) begin
              cmd_o.res_load = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_HEAD;
              cmd_o.cnt_op = CNT_ONE;
              state_d      = ST_WALK;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_fail = 1'b1;
            state_d        = ST_IDLE;
          end
        endcase
      end
      ST_INS1: begin
        if (sts_i.link_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_fail = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.save_j = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
          state_d      = ST_INS2;
        end
      end
      ST_INS2: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_ZERO;
        cmd_o.lwr_data = LD_LINK;
        cmd_o.ewr_en   = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_HEAD;
        cmd_o.cnt_op   = CNT_ONE;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.hit) begin
          case (sts_i.func) inside
            FN_INSERT: state_d = ST_INS3;
            FN_DELETE: begin
              cmd_o.save_j = 1'b1;
              cmd_o.save_k = 1'b1;
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_LINK;
              state_d      = ST_DEL2;
            end
            FN_READ: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_vsel = V_ELEM;
              state_d        = ST_IDLE;
            end
            default: begin
              cmd_o.save_k = 1'b1;
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ZERO;
              state_d      = ST_CLR2;
            end
          endcase
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
          cmd_o.cnt_op = CNT_INC;
        end
      end
      ST_INS3: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_J;
        cmd_o.lwr_data = LD_LINK;
        state_d        = ST_INS4;
      end
      ST_INS4: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_ADDR;
        cmd_o.lwr_data = LD_J;
        cmd_o.len_op   = LEN_INC;
        cmd_o.res_load = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_DEL2: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_K;
        cmd_o.lwr_data = LD_LINK;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_ZERO;
        state_d        = ST_DEL3;
      end
      ST_DEL3: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_J;
        cmd_o.lwr_data = LD_LINK;
        state_d        = ST_DEL4;
      end
      ST_DEL4: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_ZERO;
        cmd_o.lwr_data = LD_J;
        cmd_o.len_op   = LEN_DEC;
        cmd_o.res_load = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_CLR2: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_K;
        cmd_o.lwr_data = LD_LINK;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_HEAD;
        state_d        = ST_CLR3;
      end
      ST_CLR3: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_ZERO;
        cmd_o.lwr_data = LD_LINK;
        state_d        = ST_CLR4;
      end
      ST_CLR4: begin
        cmd_o.lwr_en   = 1'b1;
        cmd_o.lwr_addr = LA_HEAD;
        cmd_o.lwr_data = LD_NULL;
        cmd_o.len_op   = LEN_CLR;
        cmd_o.res_load = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.match) begin
          case (sts_i.func) inside
            FN_LOCATE: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_fpos = 1'b1;
              state_d        = ST_IDLE;
            end
            FN_PRED: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_fail = !sts_i.cnt_gt1;
              cmd_o.res_vsel = V_PREV;
              state_d        = ST_IDLE;
            end
            default: begin
              if (sts_i.cnt_eq_len) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_fail = 1'b1;
                state_d        = ST_IDLE;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RD_LINK;
                state_d      = ST_SNEXT;
              end
            end
          endcase
        end else if (sts_i.link_zero || sts_i.cnt_eq_len) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_fail = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
          cmd_o.cnt_op = CNT_INC;
        end
      end
      ST_SNEXT: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_vsel = V_ELEM;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
